[rtl/vcsa_pkg.sv]
// ----------------------------------------------------------------------------
// vcsa_pkg
// Shared types and codes of the round-robin switch allocator: the item and
// result payloads, the decoded command that passes from the front part to
// the back part, and the back part's state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vcsa_pkg;

	localparam int PORT_W = 3;
	localparam int VC_W   = 2;
	localparam int INFO_W = PORT_W + VC_W;

	typedef enum logic [1:0] {
		FN_REQUEST = 2'd0,
		FN_CLEAR   = 2'd1,
		FN_PICK    = 2'd2,
		FN_TICK    = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [PORT_W-1:0] out_port;
		logic [VC_W-1:0]   out_vc;
		logic [PORT_W-1:0] in_port;
		logic [VC_W-1:0]   in_vc;
	} item_t;

	typedef struct packed {
		logic              grant_valid;
		logic [PORT_W-1:0] grant_port;
		logic [VC_W-1:0]   grant_vc;
		logic              no_winner_error;
		logic              slot_requested;
		logic              all_empty;
	} result_t;

	// decoded item as queued between front and back
	typedef struct packed {
		func_t             func;
		logic [PORT_W-1:0] out_port;
		logic [VC_W-1:0]   out_vc;
		logic [PORT_W-1:0] in_port;
		logic [VC_W-1:0]   in_vc;
		logic              port_ok;
		logic              slot_ok;
	} cmd_t;

	typedef enum logic {
		BK_EXEC = 1'b0,
		BK_DONE = 1'b1
	} bk_state_t;

endpackage

`default_nettype wire

[rtl/vcsa_ram.sv]
// ----------------------------------------------------------------------------
// vcsa_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/vcsa_front.sv]
// ----------------------------------------------------------------------------
// vcsa_front
// Accepts items, checks their coordinates against the configured port and
// vc counts, and holds the decoded commands in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_front #(
	parameter int NUM_PORTS = 5,
	parameter int NUM_VCS   = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire vcsa_pkg::item_t req_data,
	output logic                 head_valid,
	output vcsa_pkg::cmd_t       head,
	input  wire logic            pop
);

	import vcsa_pkg::*;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t               queue_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	cmd_t               cmd;
	logic               push;
	logic               take;

	always_comb begin
		cmd.func     = func_t'(req_data.func);
		cmd.out_port = req_data.out_port;
		cmd.out_vc   = req_data.out_vc;
		cmd.in_port  = req_data.in_port;
		cmd.in_vc    = req_data.in_vc;
		cmd.port_ok  = 32'(req_data.out_port) < NUM_PORTS;
		cmd.slot_ok  = cmd.port_ok && (32'(req_data.in_port) < NUM_PORTS)
			&& (32'(req_data.out_vc) < NUM_VCS);
	end

	assign req_stall  = count_q == Q_CNT_W'(Q_DEPTH);
	assign push       = req_valid && !req_stall;
	assign head_valid = count_q != '0;
	assign head       = queue_q[rd_ptr_q];
	assign take       = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/vcsa_back.sv]
// ----------------------------------------------------------------------------
// vcsa_back
// Carries out queued commands against the arbiter state: request bits,
// round-robin pointers, held winners and the requester info memory. Each
// command passes through an execute state and then a result state, which
// loads the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_back #(
	parameter int NUM_PORTS = 5,
	parameter int NUM_VCS   = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire vcsa_pkg::cmd_t head,
	output logic                pop,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output vcsa_pkg::result_t   rsp_data
);

	import vcsa_pkg::*;

	localparam int SLOTS   = NUM_PORTS * NUM_VCS;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int OP_W    = $clog2(NUM_PORTS);
	localparam int ENTRIES = NUM_PORTS * SLOTS;
	localparam int ADDR_W  = $clog2(ENTRIES);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [SLOTS-1:0]   req_q  [NUM_PORTS];
	logic [SLOT_W-1:0]  rr_q   [NUM_PORTS];
	logic [INFO_W-1:0]  held_q [NUM_PORTS];
	logic [NUM_PORTS-1:0] won_q;
	logic               gv_q;
	logic               err_q;
	logic               fresh_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [OP_W-1:0]    op;
	logic [SLOT_W-1:0]  slot;
	logic [SLOTS-1:0]   row;
	logic [SLOTS-1:0]   above;
	logic [SLOTS-1:0]   masked;
	logic [SLOTS-1:0]   pick_src;
	logic [SLOTS-1:0]   lowest;
	logic [SLOT_W-1:0]  win_slot;
	logic               row_any;
	logic               any_req;
	logic               exec;
	logic               load;
	logic               pick_go;
	logic               grant_ok;
	logic               ram_we;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [INFO_W-1:0]  ram_rdata;
	logic [INFO_W-1:0]  grant_info;
	result_t            res;

	assign op   = OP_W'(head.out_port);
	assign slot = SLOT_W'(32'(head.in_port) * NUM_VCS + 32'(head.out_vc));
	assign row  = req_q[op];

	// circular search: slots above the pointer first, then wrap to the lowest
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			above[i] = SLOT_W'(i) > rr_q[op];
		end
		masked   = row & above;
		pick_src = (|masked) ? masked : row;
		lowest   = pick_src & (~pick_src + SLOTS'(1));
		win_slot = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (lowest[i]) begin
				win_slot = win_slot | SLOT_W'(i);
			end
		end
	end

	assign row_any = |row;

	always_comb begin
		any_req = 1'b0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			any_req = any_req | (|req_q[p]);
		end
	end

	assign exec     = (state_q == BK_EXEC) && head_valid;
	assign grant_ok = head.port_ok && (won_q[op] || row_any);
	assign pick_go  = head.port_ok && !won_q[op] && row_any;

	assign ram_we    = exec && (head.func == FN_REQUEST) && head.slot_ok;
	assign ram_re    = exec && (head.func == FN_PICK) && pick_go;
	assign ram_waddr = ADDR_W'(32'(op) * SLOTS + 32'(slot));
	assign ram_raddr = ADDR_W'(32'(op) * SLOTS + 32'(win_slot));

	vcsa_ram #(
		.WIDTH(INFO_W),
		.DEPTH(ENTRIES)
	) u_info_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({head.in_port, head.in_vc}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			BK_EXEC: begin
				if (head_valid) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					load    = 1'b1;
					pop     = 1'b1;
					state_d = BK_EXEC;
				end
			end
			default: begin
				state_d = BK_EXEC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_EXEC;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				req_q[p]  <= '0;
				rr_q[p]   <= SLOT_W'(SLOTS - 1);
				held_q[p] <= '0;
			end
			won_q <= '0;
		end else begin
			if (exec) begin
				case (head.func)
					FN_REQUEST: begin
						if (head.slot_ok) begin
							req_q[op][slot] <= 1'b1;
						end
					end
					FN_CLEAR: begin
						if (head.slot_ok) begin
							req_q[op][slot] <= 1'b0;
						end
					end
					FN_PICK: begin
						if (pick_go) begin
							rr_q[op]  <= win_slot;
							won_q[op] <= 1'b1;
						end
					end
					FN_TICK: begin
						won_q <= '0;
					end
					default: begin
					end
				endcase
			end
			// a fresh winner's info arrives from memory in the result cycle
			if (load && fresh_q) begin
				held_q[op] <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			gv_q    <= (head.func == FN_PICK) && grant_ok;
			err_q   <= (head.func == FN_PICK) && !grant_ok;
			fresh_q <= (head.func == FN_PICK) && pick_go;
		end
	end

	always_comb begin
		grant_info          = fresh_q ? ram_rdata : held_q[op];
		res.grant_valid     = gv_q;
		res.grant_port      = gv_q ? grant_info[INFO_W-1:VC_W] : '0;
		res.grant_vc        = gv_q ? grant_info[VC_W-1:0] : '0;
		res.no_winner_error = err_q;
		res.slot_requested  = head.slot_ok && req_q[op][slot];
		res.all_empty       = !any_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire

[rtl/vc_switch_round_robin_allocator_top.sv]
// ----------------------------------------------------------------------------
// vc_switch_round_robin_allocator_top
// Switch allocator with one round-robin arbiter per output port. Requests
// and clears set and reset slots, a pick grants the output's held winner or
// else the next requested slot after its pointer, a tick ends the router cycle.
//
//   channel  direction  payload   handshake
//   req      in         item_t    req_valid / req_stall
//   rsp      out        result_t  rsp_valid / rsp_stall
//
// Each item yields exactly one result. The back part first updates the
// arbiter state and launches the requester info read, then forms the result
// and loads the output register.
// A two-entry queue lets the front take items while the back is busy.
// Reset clears all request bits and held flags and sets every pointer to
// the last slot; requester info memory needs no clearing.
// A stalled result holds in the output register while the back waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vc_switch_round_robin_allocator_top #(
	parameter int NUM_PORTS = 5,
	parameter int NUM_VCS   = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire vcsa_pkg::item_t   req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output vcsa_pkg::result_t      rsp_data
);

	import vcsa_pkg::*;

	logic head_valid;
	cmd_t head;
	logic pop;

	vcsa_front #(
		.NUM_PORTS(NUM_PORTS),
		.NUM_VCS  (NUM_VCS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	vcsa_back #(
		.NUM_PORTS(NUM_PORTS),
		.NUM_VCS  (NUM_VCS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

[rtl/vcsa_checker.sv]
// ----------------------------------------------------------------------------
// vcsa_checker
// Port-level checks on the allocator's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_stall,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire vcsa_pkg::result_t rsp_data
);

	import vcsa_pkg::*;

	logic req_seen;
	assign req_seen = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_grant_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.grant_valid && rsp_data.no_winner_error))
		else $error("grant and no-winner error together");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.grant_valid |->
			rsp_data.grant_port == '0 && rsp_data.grant_vc == '0)
		else $error("grant fields set without a grant");

	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.all_empty |-> !rsp_data.slot_requested)
		else $error("slot requested while all slots empty");

	a_no_rsp_from_reset: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid || req_seen || $past(req_seen) || !$past(arst_n))
		else $error("result shown right after reset");

endmodule

bind vc_switch_round_robin_allocator_top vcsa_checker u_vcsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp_data (rsp_data)
);

`default_nettype wire
